// File: design/wdm_pkg.sv
package wdm_pkg;

    localparam int SAMPLE_BITS      = 24;
    localparam int MAX_CHANNELS_DEF = 8;
    localparam int FPP_W            = 16;
    localparam int CC_W             = 4;
    localparam int CFG_DATA_W       = 16;
    localparam int CFG_IDX_W        = 1;

    localparam logic [FPP_W-1:0] FPP_RESET = 16'd256;
    localparam logic [CC_W-1:0]  CC_RESET  = 4'd2;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_POINT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT    = 1'd1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] point_min;
        logic signed [SAMPLE_BITS-1:0] point_max;
        logic [FPP_W-1:0]              frames_covered;
        logic                          is_partial;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic take;       // input transfer this cycle
        logic div_start;  // load divider with completed frame sum
        logic commit;     // apply frame/flush result, load output if any
    } ctrl_cmd_t;

    typedef struct packed {
        logic frame_done; // current input completes a frame
        logic eos_in;     // current input carries end of stream
        logic div_done;   // divider finished
        logic emit;       // finish step produces a point
        logic out_busy;   // output register still holds an untaken point
    } dp_status_t;

endpackage

// File: design/wdm_divider.sv
module wdm_divider
    import wdm_pkg::*;
#(
    parameter int SUM_W = 27,
    parameter int CH_W  = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [SUM_W-1:0]       dividend,
    input  logic [CH_W-1:0]               divisor,
    output logic                          done,
    output logic signed [SAMPLE_BITS-1:0] quotient
);

    localparam int CNT_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic [SUM_W-1:0] mag_reg;
    logic [CH_W-1:0]  rem_reg;
    logic [CH_W-1:0]  div_reg;

    logic [CH_W:0]    rem_sh;
    logic             q_bit;
    logic [CH_W-1:0]  rem_next;
    logic [SUM_W-1:0] mag_next;
    logic [SUM_W-1:0] q_signed;

    // one restoring step per cycle on the magnitude
    always_comb begin
        rem_sh   = {rem_reg, mag_reg[SUM_W-1]};
        q_bit    = (rem_sh >= {1'b0, div_reg});
        rem_next = q_bit ? CH_W'(rem_sh - {1'b0, div_reg}) : CH_W'(rem_sh);
        mag_next = {mag_reg[SUM_W-2:0], q_bit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[SUM_W-1];
            mag_reg <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            mag_reg <= mag_next;
            rem_reg <= rem_next;
        end
    end

    assign q_signed = neg_reg ? SUM_W'(~mag_reg + SUM_W'(1)) : mag_reg;
    assign quotient = q_signed[SAMPLE_BITS-1:0];
    assign done     = done_reg;

endmodule

// File: design/wdm_datapath.sv
module wdm_datapath
    import wdm_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  in_item_t              s_item,
    input  logic                  m_ready,
    output logic                  m_valid,
    output out_item_t             m_item,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            st
);

    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_CHANNELS);
    localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
    localparam int CI_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [FPP_W-1:0]              fpp_reg;
    logic [CC_W-1:0]               cc_reg;
    logic [CI_W-1:0]               ci_reg;
    logic signed [SUM_W-1:0]       frame_sum_reg;
    logic signed [SAMPLE_BITS-1:0] run_min_reg;
    logic signed [SAMPLE_BITS-1:0] run_max_reg;
    logic [FPP_W-1:0]              fig_reg;
    logic                          eos_reg;
    logic                          fd_reg;
    logic                          m_valid_reg;
    out_item_t                     m_item_reg;

    logic [CH_W-1:0]               chans;
    logic [FPP_W-1:0]              fpp_eff;
    logic                          frame_done;
    logic [CI_W-1:0]               ci_next;
    logic signed [SUM_W-1:0]       sample_ext;
    logic signed [SUM_W-1:0]       sum_next;
    logic                          div_done;
    logic signed [SAMPLE_BITS-1:0] mono;

    logic signed [SAMPLE_BITS-1:0] pt_min;
    logic signed [SAMPLE_BITS-1:0] pt_max;
    logic [FPP_W-1:0]              fig_inc;
    logic [FPP_W-1:0]              fig_n;
    logic                          grp_done;
    logic                          emit;
    logic                          out_busy;
    out_item_t                     point;

    // effective register values: zero counts act as one, channels clamp
    always_comb begin
        if (cc_reg == '0) begin
            chans = CH_W'(1);
        end else if (int'(cc_reg) > MAX_CHANNELS) begin
            chans = CH_W'(MAX_CHANNELS);
        end else begin
            chans = CH_W'(cc_reg);
        end
        fpp_eff = (fpp_reg == '0) ? FPP_W'(1) : fpp_reg;
    end

    assign frame_done = (int'(ci_reg) + 1) >= int'(chans);
    assign ci_next    = CI_W'((int'(ci_reg) + 1) & (2 * MAX_CHANNELS - 1));
    assign sample_ext = SUM_W'(s_item.sample);
    assign sum_next   = frame_sum_reg + sample_ext;

    wdm_divider #(
        .SUM_W (SUM_W),
        .CH_W  (CH_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum_next),
        .divisor  (chans),
        .done     (div_done),
        .quotient (mono)
    );

    // finish step: fold in the mono value if a frame completed, decide on a point
    always_comb begin
        fig_inc = fig_reg + FPP_W'(1);
        if (fd_reg) begin
            pt_min   = (mono < run_min_reg) ? mono : run_min_reg;
            pt_max   = (mono > run_max_reg) ? mono : run_max_reg;
            fig_n    = fig_inc;
            grp_done = (fig_inc >= fpp_eff) || (fig_inc == '0);
        end else begin
            pt_min   = run_min_reg;
            pt_max   = run_max_reg;
            fig_n    = fig_reg;
            grp_done = 1'b0;
        end
        emit                 = grp_done || (eos_reg && (fig_n != '0));
        point.point_min      = pt_min;
        point.point_max      = pt_max;
        point.frames_covered = (fig_n == '0) ? {FPP_W{1'b1}} : fig_n;
        point.is_partial     = !grp_done;
    end

    assign out_busy = m_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fpp_reg <= FPP_RESET;
            cc_reg  <= CC_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FRAMES_PER_POINT: fpp_reg <= cfg_wdata[FPP_W-1:0];
                CFG_CHANNEL_COUNT:    cc_reg  <= cfg_wdata[CC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ci_reg        <= '0;
            frame_sum_reg <= '0;
            run_min_reg   <= SAMPLE_MAX;
            run_max_reg   <= SAMPLE_MIN;
            fig_reg       <= '0;
            eos_reg       <= 1'b0;
            fd_reg        <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.take) begin
                eos_reg <= s_item.end_of_stream;
                fd_reg  <= frame_done;
                if (frame_done) begin
                    ci_reg        <= '0;
                    frame_sum_reg <= '0;
                end else begin
                    ci_reg        <= ci_next;
                    frame_sum_reg <= sum_next;
                end
            end
            if (cmd.commit) begin
                if (grp_done || eos_reg) begin
                    run_min_reg <= SAMPLE_MAX;
                    run_max_reg <= SAMPLE_MIN;
                    fig_reg     <= '0;
                end else begin
                    run_min_reg <= pt_min;
                    run_max_reg <= pt_max;
                    fig_reg     <= fig_n;
                end
                if (eos_reg) begin
                    ci_reg        <= '0;
                    frame_sum_reg <= '0;
                end
            end
            if (cmd.commit && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && emit) begin
            m_item_reg <= point;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_item        = m_item_reg;
    assign st.frame_done = frame_done;
    assign st.eos_in     = s_item.end_of_stream;
    assign st.div_done   = div_done;
    assign st.emit       = emit;
    assign st.out_busy   = out_busy;

endmodule

// File: design/wdm_ctrl.sv
module wdm_ctrl
    import wdm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t st,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_ready       = 1'b0;
        cmd.take      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.commit    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take = 1'b1;
                    if (st.frame_done) begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIVIDE;
                    end else if (st.eos_in) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_DIVIDE: begin
                if (st.div_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold while a new point has nowhere to go
                if (!(st.emit && st.out_busy)) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/waveform_min_max_decimator.sv
// Points: a frame-completing sample gives its point after the serial divider and FINISH;
//   an end-of-stream flush alone goes from IDLE straight to FINISH.
// Throughput: one sample per cycle within a frame; the last sample of a frame holds the
//   input through the serial divide and FINISH, an end-of-stream sample through FINISH.
// Reset (aresetn low, synchronous): frames_per_point=256, channel_count=2, stream state
//   cleared, output empty.
module waveform_min_max_decimator
    import wdm_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // sample input, one channel per transfer
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    // min/max points
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item
);

    // Structure:
    //   wdm_ctrl     - three-state sequencer: IDLE takes samples, DIVIDE waits on the
    //                  divider after the last channel of a frame, FINISH folds any new mono
    //                  value into min/max and loads the output register if a point is due.
    //   wdm_datapath - config registers, channel index, frame sum, running min/max,
    //                  frame count, output register, and the serial divider.
    // The frame sum is divided by the channel count with truncation toward zero,
    // one quotient bit per cycle on the magnitude, sign applied at the end.
    // The output register decouples the sides: the next sample is taken while a
    // point waits; FINISH stalls only if a second point would overwrite it.

    ctrl_cmd_t  cmd;
    dp_status_t st;

    wdm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    wdm_datapath #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_item    (s_item),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_item    (m_item),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

// File: dv/tb.sv
module tb;
    import wdm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // run bounds
    localparam int RANDOM_ITEMS  = 1600;
    localparam int SETTLE_CYCLES = SAMPLE_BITS + $clog2(MAX_CHANNELS_DEF) + 12;
    localparam int LONG_HOLD     = 400;
    localparam int END_WAIT      = 20000;
    localparam int LIMIT_CYCLES  = 1000000;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_MOSTLY,
        RX_PATTERN
    } rx_mode_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_FRAMES_PER_POINT;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_item    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_item;

    waveform_min_max_decimator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    // 12 ns period
    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Mirror of the block: register copies plus the stream state.
    // ------------------------------------------------------------------
    logic [FPP_W-1:0] cfg_fpp   = FPP_RESET;
    logic [CC_W-1:0]  cfg_chans = CC_RESET;

    int               chan_pos   = 0;   // channels already taken in this frame
    longint           acc_sum    = 0;   // frame sum, full precision
    longint           grp_min    = longint'(SAMPLE_MAX);
    longint           grp_max    = longint'(SAMPLE_MIN);
    logic [FPP_W-1:0] grp_frames = '0;

    out_item_t expected_points[$];

    int errors = 0;
    int cycles = 0;

    // sender burst shaping
    bit gaps_on    = 1'b1;
    int burst_left = 0;

    // receiver stall control; hold_left is a forced long stall
    int       hold_left = 0;
    int       mode_left = 0;
    int       rx_phase  = 0;
    rx_mode_t rx_mode   = RX_ALWAYS;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // channel_count 0 acts as 1, anything above MAX_CHANNELS is clamped
    function automatic int eff_chans(input logic [CC_W-1:0] c);
        if (c == 0)
            return 1;
        if (int'(c) > MAX_CHANNELS_DEF)
            return MAX_CHANNELS_DEF;
        return int'(c);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        logic signed [SAMPLE_BITS-1:0] v;
        int                            t;
        case ($urandom_range(0, 9))
            0: v = SAMPLE_MAX;
            1: v = SAMPLE_MIN;
            2: begin
                t = int'($urandom_range(0, 8)) - 4;
                v = SAMPLE_BITS'(t);
            end
            default: v = SAMPLE_BITS'($urandom);
        endcase
        return v;
    endfunction

    function automatic void clear_stream_state();
        chan_pos   = 0;
        acc_sum    = 0;
        grp_min    = longint'(SAMPLE_MAX);
        grp_max    = longint'(SAMPLE_MIN);
        grp_frames = '0;
    endfunction

    // Advance the mirror by one accepted sample; queue the point it yields.
    function automatic void predict_point(input in_item_t it);
        int        chans;
        int        fpp;
        longint    mono;
        bit        emitted;
        out_item_t pt;
        chans   = eff_chans(cfg_chans);
        fpp     = (cfg_fpp == 0) ? 1 : int'(cfg_fpp);
        emitted = 1'b0;
        acc_sum += longint'(it.sample);
        // a frame also closes when the count dropped below the position
        if (chan_pos + 1 >= chans) begin
            mono = acc_sum / longint'(chans);  // truncates toward zero
            if (mono < grp_min)
                grp_min = mono;
            if (mono > grp_max)
                grp_max = mono;
            grp_frames = grp_frames + 1'b1;
            chan_pos   = 0;
            acc_sum    = 0;
            if (int'(grp_frames) >= fpp) begin
                pt.point_min      = grp_min[SAMPLE_BITS-1:0];
                pt.point_max      = grp_max[SAMPLE_BITS-1:0];
                pt.frames_covered = grp_frames;
                pt.is_partial     = 1'b0;
                expected_points   = {expected_points, pt};
                emitted    = 1'b1;
                grp_min    = longint'(SAMPLE_MAX);
                grp_max    = longint'(SAMPLE_MIN);
                grp_frames = '0;
            end
        end else begin
            chan_pos++;
        end
        // end of stream: flush an unfinished group, drop any partial frame
        if (it.end_of_stream) begin
            if (!emitted && grp_frames != 0) begin
                pt.point_min      = grp_min[SAMPLE_BITS-1:0];
                pt.point_max      = grp_max[SAMPLE_BITS-1:0];
                pt.frames_covered = grp_frames;
                pt.is_partial     = 1'b1;
                expected_points   = {expected_points, pt};
            end
            clear_stream_state();
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: checks result transfers, then predicts from input transfers,
    // then applies register writes. One block keeps the order fixed.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        out_item_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_points.size() == 0) begin
                    report_mismatch("point with none expected", longint'(m_item.point_min), 0);
                end else begin
                    want = expected_points.pop_front();
                    if (m_item.point_min !== want.point_min)
                        report_mismatch("point_min", longint'(m_item.point_min),
                                        longint'(want.point_min));
                    if (m_item.point_max !== want.point_max)
                        report_mismatch("point_max", longint'(m_item.point_max),
                                        longint'(want.point_max));
                    if (m_item.frames_covered !== want.frames_covered)
                        report_mismatch("frames_covered", longint'(m_item.frames_covered),
                                        longint'(want.frames_covered));
                    if (m_item.is_partial !== want.is_partial)
                        report_mismatch("is_partial", longint'(m_item.is_partial),
                                        longint'(want.is_partial));
                end
            end
            if (s_valid && s_ready)
                predict_point(s_item);
            if (cfg_we) begin
                if (cfg_index == CFG_FRAMES_PER_POINT)
                    cfg_fpp = cfg_wdata[FPP_W-1:0];
                else if (cfg_index == CFG_CHANNEL_COUNT)
                    cfg_chans = cfg_wdata[CC_W-1:0];
            end
        end
    end

    // Receiver: random stall modes, overridden by a long forced hold
    // when a test asks for one.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            rx_phase++;
            case (rx_mode)
                RX_ALWAYS: m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_MOSTLY: m_ready <= ($urandom_range(0, 7) != 0);
                default:   m_ready <= ((rx_phase % 5) < 2);
            endcase
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // One sample transfer; valid stays high into the next call unless a gap opens.
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic eos);
        int gap;
        gap = 0;
        if (gaps_on) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(0, 7);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid              <= 1'b1;
        s_item.sample        <= smp;
        s_item.end_of_stream <= eos;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    // Sender pause: drop valid, wait for every point, then let the divider settle
    // in case the last frame closed without a point.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_idle();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset values of the registers: two channels, group far from full,
    // so end of stream flushes a one-frame partial point
    task automatic test_reset_defaults();
        send_sample(SAMPLE_BITS'(1000), 1'b0);
        send_sample(SAMPLE_BITS'(-3001), 1'b1);
    endtask

    // full-scale samples, single and eight-channel frames
    task automatic test_sample_extremes();
        int k;
        write_reg(CFG_FRAMES_PER_POINT, 16'd1);
        write_reg(CFG_CHANNEL_COUNT, 16'd1);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        // channel count above the limit clamps to eight; upper bits ignored
        write_reg(CFG_CHANNEL_COUNT, 16'hA5F9);
        for (k = 0; k < MAX_CHANNELS_DEF; k++)
            send_sample(SAMPLE_MIN, 1'b0);
    endtask

    task automatic test_special_cases();
        // zero count and zero group size act as one; the group closes on the
        // end-of-stream sample, so only a full point comes out
        write_reg(CFG_FRAMES_PER_POINT, 16'd0);
        write_reg(CFG_CHANNEL_COUNT, 16'h5550);
        send_sample(SAMPLE_BITS'(-1), 1'b1);
        // divide truncates toward zero for negative sums
        write_reg(CFG_FRAMES_PER_POINT, 16'd2);
        write_reg(CFG_CHANNEL_COUNT, 16'd3);
        send_sample(SAMPLE_BITS'(-1), 1'b0);
        send_sample(SAMPLE_BITS'(-1), 1'b0);
        send_sample(SAMPLE_BITS'(0), 1'b0);
        send_sample(SAMPLE_BITS'(-5), 1'b0);
        send_sample(SAMPLE_BITS'(0), 1'b0);
        send_sample(SAMPLE_BITS'(0), 1'b0);
        // end of stream with an empty group and a dangling partial frame
        send_sample(SAMPLE_BITS'(7), 1'b1);
    endtask

    // register changes land mid-frame and mid-group and apply at once
    task automatic test_mid_stream_config();
        write_reg(CFG_FRAMES_PER_POINT, 16'd1);
        write_reg(CFG_CHANNEL_COUNT, 16'd2);
        send_sample(SAMPLE_BITS'(100), 1'b0);
        write_reg(CFG_CHANNEL_COUNT, 16'd1);
        send_sample(SAMPLE_BITS'(23), 1'b0);
        // group already past the new size: point reports the true frame count
        write_reg(CFG_FRAMES_PER_POINT, 16'd4);
        send_sample(rand_sample(), 1'b0);
        send_sample(rand_sample(), 1'b0);
        send_sample(rand_sample(), 1'b0);
        write_reg(CFG_FRAMES_PER_POINT, 16'd2);
        send_sample(rand_sample(), 1'b0);
    endtask

    // long receiver hold with one point per sample: block fills, input stalls
    task automatic test_output_stall();
        int k;
        write_reg(CFG_FRAMES_PER_POINT, 16'd1);
        write_reg(CFG_CHANNEL_COUNT, 16'd1);
        gaps_on = 1'b0;
        @(posedge aclk);
        hold_left = LONG_HOLD;
        for (k = 0; k < 40; k++)
            send_sample(rand_sample(), 1'($urandom_range(0, 9) == 0));
        gaps_on = 1'b1;
    endtask

    // Phases of random settings. Most streams are whole frames closed by end of
    // stream; the rest stop mid-stream or carry stray end-of-stream flags.
    task automatic test_random_streams();
        int               sent;
        int               total;
        int               chans;
        int               cut;
        int               k;
        bit               clean;
        bit               stop_early;
        logic             eos;
        logic [FPP_W-1:0] fpp_v;
        logic [15:0]      cc_v;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0:          fpp_v = 16'd0;
                1:          fpp_v = 16'hFFFF;
                2:          fpp_v = 16'($urandom);
                3, 4, 5:    fpp_v = 16'($urandom_range(9, 40));
                default:    fpp_v = 16'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 15))
                0:          cc_v = 16'($urandom) & 16'hFFF0;
                1:          cc_v = (16'($urandom) & 16'hFFF0) | 16'($urandom_range(9, 15));
                2:          cc_v = 16'($urandom);
                default:    cc_v = 16'($urandom_range(1, 8));
            endcase
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_FRAMES_PER_POINT, fpp_v);
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_CHANNEL_COUNT, cc_v);
            gaps_on    = ($urandom_range(0, 3) != 0);
            chans      = eff_chans(cfg_chans);
            total      = $urandom_range(1, 24) * chans;
            clean      = ($urandom_range(0, 4) != 0);
            stop_early = 1'($urandom_range(0, 1));
            cut        = $urandom_range(0, total - 1);
            for (k = 0; k < total; k++) begin
                if (!clean && stop_early && k == cut)
                    break;
                if (clean)
                    eos = (k == total - 1);
                else
                    eos = (k == cut) || ($urandom_range(0, 19) == 0);
                send_sample(rand_sample(), eos);
                sent++;
            end
        end
    endtask

    initial begin
        int wait_cnt;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_sample_extremes();
        test_special_cases();
        test_mid_stream_config();
        test_output_stall();
        test_random_streams();

        // drain: wait for outstanding points, bounded, then a settle window
        @(negedge aclk);
        s_valid <= 1'b0;
        wait_cnt = 0;
        while (expected_points.size() != 0 && wait_cnt < END_WAIT) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_points.size() != 0)
            report_mismatch("points never produced", 0, expected_points.size());

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
